// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qphs_pkg.sv =====
// shared types and constants of the quadratic probing hash set
// no dependencies
package qphs_pkg;

    localparam int KEY_W      = 31;
    localparam int SIZE_W     = 7;
    localparam int REQ_W      = 2;
    localparam int CNT_W      = $clog2(KEY_W);
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    // one slot of the table
    typedef struct packed {
        logic             used;
        logic             deleted;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/quadratic_probe_hash_set.sv =====
// quadratic probing hash set with tombstones, table held in one ram
// depends on qphs_pkg, qphs_ram, qphs_mod
//
//  channel   dir  signals                       contents
//  s_axis    in   tvalid tready tdata tuser     key, request type
//  m_axis    out  tvalid tready tdata           found, insert_failed, element_count
//  cfg       in   cfg_we cfg_wdata              table_size
//
// an item runs from one input transfer to the next through the serial key mod
// size unit (31 bit steps, then done), a ram read and a check per probe, the
// finish state that posts the result and a return to idle; a nop request goes
// straight from idle to finish
// after reset a clearing pass writes every slot with s_axis_tready low
// one item at a time; a finished result holds in the output register and a
// stalled output only holds the block in its finish state
module quadratic_probe_hash_set #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // key [30:0]
    input  logic [qphs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [qphs_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // found [0], insert_failed [1], element_count [8:2]
    output logic [qphs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_we,
    input  logic [qphs_pkg::SIZE_W-1:0]     cfg_wdata
);
    import qphs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    function automatic logic [SIZE_W-1:0] mod_add(
        input logic [SIZE_W-1:0] a,
        input logic [SIZE_W-1:0] b,
        input logic [SIZE_W-1:0] m
    );
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[SIZE_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  table_size_reg;
    logic [SIZE_W-1:0]  eff_size;
    logic [AW-1:0]      clr_addr_reg;
    logic [KEY_W-1:0]   key_reg;
    req_t               req_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  pos_reg;
    logic [SIZE_W-1:0]  off_reg;
    logic [SIZE_W-1:0]  d_reg;
    logic [SIZE_W-1:0]  iter_reg;
    logic [SIZE_W-1:0]  count_reg;
    logic               found_reg;
    logic               fail_reg;
    logic               m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic               in_xfer;
    logic               out_load;
    logic               mod_start;
    logic               mod_done;
    logic [SIZE_W-1:0]  mod_rem;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [SIZE_W-1:0]  iter_inc;
    logic [SIZE_W-1:0]  off_step;
    logic [SIZE_W-1:0]  pos_step;
    logic [SIZE_W-1:0]  d_step;
    logic               is_free;
    logic               is_match;
    logic               chk_insert;
    logic               chk_delete;
    logic               chk_found;
    logic               chk_fail;
    logic               chk_step;

    // effective size: zero acts as one, capped at the table depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign mod_start = in_xfer && (req_t'(s_axis_tuser[REQ_W-1:0]) != REQ_NOP);
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    // probe step: offset i*i grows by 2i-1, all mod size
    assign iter_inc = iter_reg + 1'b1;
    assign off_step = mod_add(off_reg, d_reg, size_reg);
    assign pos_step = mod_add(pos_reg, off_step, size_reg);
    assign d_step   = mod_add(mod_add(d_reg, SIZE_W'(1), size_reg), SIZE_W'(1), size_reg);

    // slot check
    always_comb
    begin
        is_free    = !ram_rdata.used || ram_rdata.deleted;
        is_match   = ram_rdata.used && !ram_rdata.deleted && (ram_rdata.key == key_reg);
        chk_insert = 1'b0;
        chk_delete = 1'b0;
        chk_found  = 1'b0;
        chk_fail   = 1'b0;
        chk_step   = 1'b0;
        if (state_reg == ST_CHECK)
        begin
            if (req_reg == REQ_INSERT)
            begin
                if (is_free)
                begin
                    chk_insert = 1'b1;
                end
                else if (iter_inc >= size_reg)
                begin
                    chk_fail = 1'b1;
                end
                else
                begin
                    chk_step = 1'b1;
                end
            end
            else if (ram_rdata.used)
            begin
                if (is_match)
                begin
                    chk_found  = 1'b1;
                    chk_delete = (req_reg == REQ_DELETE);
                end
                else if (iter_inc < size_reg)
                begin
                    chk_step = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = mod_start ? ST_MOD : ST_FINISH;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = chk_step ? ST_READ : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: handshake and ram write port
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(pos_reg);
        ram_wdata     = '{used: 1'b1, deleted: 1'b0, key: key_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_CHECK:
            begin
                ram_we            = chk_insert || chk_delete;
                ram_wdata.deleted = chk_delete;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            table_size_reg <= SIZE_RESET;
            clr_addr_reg   <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (chk_insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (chk_delete)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per item datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            req_reg   <= req_t'(s_axis_tuser[REQ_W-1:0]);
            size_reg  <= eff_size;
            iter_reg  <= '0;
            off_reg   <= '0;
            d_reg     <= mod_add('0, SIZE_W'(1), eff_size);
            found_reg <= 1'b0;
            fail_reg  <= 1'b0;
        end
        if (mod_done)
        begin
            pos_reg <= mod_rem;
        end
        if (chk_step)
        begin
            iter_reg <= iter_inc;
            off_reg  <= off_step;
            pos_reg  <= pos_step;
            d_reg    <= d_step;
        end
        if (chk_found)
        begin
            found_reg <= 1'b1;
        end
        if (chk_fail)
        begin
            fail_reg <= 1'b1;
        end
        if (out_load)
        begin
            m_data_reg <= OUT_DATA_W'({count_reg, fail_reg, found_reg});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // key mod size
    qphs_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (s_axis_tdata[KEY_W-1:0]),
        .divisor  (eff_size),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // slot table
    qphs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(pos_reg)),
        .rdata (ram_rdata)
    );

endmodule

// ===== src/qphs_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module qphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/qphs_mod.sv =====
// serial remainder unit: key mod size, one dividend bit per cycle
// depends on qphs_pkg
module qphs_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [qphs_pkg::KEY_W-1:0]  dividend,
    input  logic [qphs_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [qphs_pkg::SIZE_W-1:0] rem
);
    import qphs_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [KEY_W-1:0]    dvd_reg;
    logic [SIZE_W-1:0]   div_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [SIZE_W:0]     trial;
    logic [SIZE_W-1:0]   rem_next;

    // restoring step: shift in the next bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            trial = trial - {1'b0, div_reg};
        end
        rem_next = trial[SIZE_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(KEY_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/qphs_checker.sv =====
// port level checks of the hash set, bound to the top level
// depends on qphs_pkg and assert_macros.svh
`include "assert_macros.svh"

module qphs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [qphs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);
    import qphs_pkg::*;

    // an accepted item closes the input
    `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a transfer")

    // a result never reports both a hit and a failed insert
    `ASSERT_ALWAYS(a_flags_exclusive, clk, rst_n, !m_axis_tvalid || !(m_axis_tdata[0] && m_axis_tdata[1]), "found and insert_failed both set")

    // a stalled result stays offered
    `ASSERT_NEXT(a_valid_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_data_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind quadratic_probe_hash_set qphs_checker u_qphs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ===== sim/tb_top.sv =====
// self-checking testbench for the quadratic probing hash set
// depends on qphs_pkg and quadratic_probe_hash_set; keeps its own copy of the table
// to predict each reply and checks the replies in order
`timescale 1ns / 100ps

module tb_top;
    import qphs_pkg::*;

    localparam int DEPTH       = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int END_CYCLES  = 200;
    localparam int PHASE_ITEMS = 78;
    localparam int POOL_MAX    = 48;

    typedef enum int {
        GAP_NONE,
        GAP_SEND,
        GAP_RECV,
        GAP_BOTH
    } gap_mode_t;

    typedef struct packed {
        req_t       req;
        logic [30:0] key;
    } op_t;

    typedef struct packed {
        logic       found;
        logic       failed;
        logic [6:0] count;
    } reply_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = REQ_NOP;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [SIZE_W-1:0]     cfg_wdata     = '0;

    // shadow copy of the table
    logic [30:0] shadow_key [DEPTH];
    bit          shadow_used [DEPTH];
    bit          shadow_dead [DEPTH];
    logic [6:0]  shadow_live;
    logic [6:0]  shadow_size;

    op_t         pending_ops[$];
    reply_t      expected_replies[$];
    logic [30:0] key_pool[$];
    op_t         cur_op;
    bit          offering;
    bit          hold_go;
    int          hold_left;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          err_cnt;
    int          quiet_cycles;
    int          n_insert, n_insert_fail, n_probe, n_hit, n_reply;

    quadratic_probe_hash_set #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // apply one request to the shadow table and return the reply it gives
    function automatic reply_t predict_reply(input req_t req, input logic [30:0] key);
        int unsigned sz;
        int unsigned pos;
        int unsigned iter;
        bit          ok;
        bit          hit;
        reply_t      r;
        sz = (shadow_size == 0) ? 1 : ((shadow_size > DEPTH) ? DEPTH : shadow_size);
        r = '0;
        pos = key % sz;
        iter = 0;
        if (req == REQ_INSERT)
        begin
            n_insert++;
            ok = 1'b1;
            // first empty or tombstone slot on the probe path
            while (shadow_used[pos] && !shadow_dead[pos])
            begin
                iter++;
                if (iter >= sz)
                begin
                    ok = 1'b0;
                    break;
                end
                pos = (pos + iter * iter) % sz;
            end
            if (ok)
            begin
                shadow_key[pos]  = key;
                shadow_used[pos] = 1'b1;
                shadow_dead[pos] = 1'b0;
                shadow_live      = shadow_live + 7'd1;
            end
            else
            begin
                r.failed = 1'b1;
                n_insert_fail++;
            end
        end
        else if (req == REQ_LOOKUP || req == REQ_DELETE)
        begin
            n_probe++;
            hit = 1'b0;
            // stop at an empty slot, a live match or after sz probes
            while (shadow_used[pos] && iter < sz)
            begin
                iter++;
                if (shadow_key[pos] == key && !shadow_dead[pos])
                begin
                    hit = 1'b1;
                    break;
                end
                pos = (pos + iter * iter) % sz;
            end
            if (hit)
            begin
                r.found = 1'b1;
                n_hit++;
                if (req == REQ_DELETE)
                begin
                    shadow_dead[pos] = 1'b1;
                    shadow_live      = shadow_live - 7'd1;
                end
            end
        end
        r.count = shadow_live;
        return r;
    endfunction

    // key source: reuse of earlier keys, small colliding keys, or full range
    function automatic logic [30:0] pick_key(input bit from_pool);
        int roll;
        roll = $urandom_range(99);
        if (from_pool && key_pool.size() > 0 && roll < 75)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        else if (roll < 85)
            return 31'($urandom_range(200));
        else
            return 31'($urandom);
    endfunction

    task automatic push_op(input req_t req, input logic [30:0] key);
        op_t op;
        op.req = req;
        op.key = key;
        pending_ops.push_back(op);
        if (req == REQ_INSERT)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_MAX)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic push_random(input int n);
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 42)
                push_op(REQ_INSERT, pick_key($urandom_range(99) < 30));
            else if (roll < 72)
                push_op(REQ_LOOKUP, pick_key(1'b1));
            else if (roll < 95)
                push_op(REQ_DELETE, pick_key(1'b1));
            else
                push_op(REQ_NOP, pick_key(1'b0));
        end
    endtask

    // wait for the block to go idle, then set the size and the gap pattern
    task automatic settle_and_size(input logic [6:0] size, input gap_mode_t mode);
        while (pending_ops.size() != 0 || offering || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= size;
        shadow_size  = size;
        @(posedge clk);
        cfg_we      <= 1'b0;
        send_idle_pct  = (mode == GAP_SEND) ? 75 : ((mode == GAP_BOTH) ? 27 : 0);
        recv_stall_pct = (mode == GAP_RECV) ? 75 : ((mode == GAP_BOTH) ? 27 : 0);
    endtask

    // input driver: offers queued items and predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= REQ_NOP;
            offering       = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_replies.push_back(predict_reply(cur_op.req, cur_op.key));
                offering = 1'b0;
            end
            if (!offering && pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_op   = pending_ops.pop_front();
                offering = 1'b1;
            end
            s_axis_tvalid <= offering;
            s_axis_tdata  <= {1'b0, cur_op.key};
            s_axis_tuser  <= cur_op.req;
        end
    end

    // output ready: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left      = 0;
        end
        else
        begin
            if (hold_go)
            begin
                hold_left = HOLD_CYCLES;
                hold_go   = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // reply monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_reply++;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, actual tdata %h", $time, m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                reply_t e;
                e = expected_replies.pop_front();
                if (m_axis_tdata[0] !== e.found)
                begin
                    $display("%0t: found mismatch, expected %0d actual %0d",
                             $time, e.found, m_axis_tdata[0]);
                    err_cnt++;
                end
                if (m_axis_tdata[1] !== e.failed)
                begin
                    $display("%0t: insert_failed mismatch, expected %0d actual %0d",
                             $time, e.failed, m_axis_tdata[1]);
                    err_cnt++;
                end
                if (m_axis_tdata[8:2] !== e.count)
                begin
                    $display("%0t: element_count mismatch, expected %0d actual %0d",
                             $time, e.count, m_axis_tdata[8:2]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // reset, directed checks, then random phases over several sizes
    initial
    begin
        logic [6:0] phase_size [12];
        phase_size = '{7'd64, 7'd5, 7'd127, 7'd16, 7'd1, 7'd33,
                       7'd64, 7'd100, 7'd8, 7'd64, 7'd2, 7'd48};
        err_cnt = 0;
        quiet_cycles = 0;
        hold_go = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_insert = 0;
        n_insert_fail = 0;
        n_probe = 0;
        n_hit = 0;
        n_reply = 0;
        shadow_live = '0;
        shadow_size = SIZE_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_key[i]  = '0;
            shadow_used[i] = 1'b0;
            shadow_dead[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // full size: key extremes, collisions, tombstones, miss on empty slot
        settle_and_size(7'd64, GAP_NONE);
        push_op(REQ_INSERT, 31'd0);
        push_op(REQ_INSERT, 31'h7FFFFFFF);
        push_op(REQ_LOOKUP, 31'd0);
        push_op(REQ_LOOKUP, 31'h7FFFFFFF);
        push_op(REQ_DELETE, 31'h7FFFFFFF);
        push_op(REQ_LOOKUP, 31'h7FFFFFFF);
        push_op(REQ_INSERT, 31'd64);
        push_op(REQ_LOOKUP, 31'd64);
        push_op(REQ_DELETE, 31'd0);
        push_op(REQ_LOOKUP, 31'd64);
        push_op(REQ_INSERT, 31'd128);
        push_op(REQ_NOP, 31'd5);
        push_op(REQ_LOOKUP, 31'd12345);
        push_op(REQ_DELETE, 31'd12345);

        // size zero acts as one slot: full table and failed inserts
        settle_and_size(7'd0, GAP_BOTH);
        push_op(REQ_DELETE, 31'd128);
        push_op(REQ_INSERT, 31'd3);
        push_op(REQ_INSERT, 31'd4);
        push_op(REQ_LOOKUP, 31'd3);
        push_op(REQ_DELETE, 31'd3);
        push_op(REQ_INSERT, 31'd9);
        push_op(REQ_NOP, 31'h55555555);

        // random phases, resizing a filled table between them
        for (int p = 0; p < 12; p++)
        begin
            settle_and_size(phase_size[p], gap_mode_t'(p % 4));
            if (p == 4)
                hold_go = 1'b1;
            push_random(PHASE_ITEMS);
        end

        while (pending_ops.size() != 0 || offering || expected_replies.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d replies: %0d inserts (%0d failed), %0d lookups/deletes (%0d hits)",
                 n_reply, n_insert, n_insert_fail, n_probe, n_hit);
        $display("table sizes 0 to 127 with and without idle cycles, one long output hold-off");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== quadratic_probe_hash_set.f =====
+incdir+src
src/qphs_pkg.sv
src/qphs_ram.sv
src/qphs_mod.sv
src/quadratic_probe_hash_set.sv
src/qphs_checker.sv
sim/tb_top.sv
